>>> hdl/stepper_position_controller_macros.svh
// Assertion macros for the stepper position controller.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef STEPPER_POSITION_CONTROLLER_MACROS_SVH
`define STEPPER_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spc_pkg.sv
// Shared types and codes for the stepper position controller.
// No dependencies; imported by every RTL module of the block.
package spc_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_GOTO = 2'd1,
    FUNC_REL  = 2'd2,
    FUNC_CAL  = 2'd3
  } func_e;

  // Mode codes (state of the controller)
  localparam logic [1:0] MODE_CAL  = 2'd0;
  localparam logic [1:0] MODE_IDLE = 2'd1;
  localparam logic [1:0] MODE_MOVE = 2'd2;

  // Step direction codes
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;

  // Request handed from the modulo pipeline to the controller core
  typedef struct packed {
    func_e       func;
    logic [15:0] amount;
    logic [15:0] amount_mod;  // amount modulo one turn, zero extended
  } spc_cmd_t;

endpackage

>>> hdl/spc_mod_reduce.sv
// Two-stage pipeline that reduces the request amount modulo one turn.
// Uses spc_pkg; feeds spc_core through a valid/ready handshake.
module spc_mod_reduce
  import spc_pkg::*;
#(
  parameter int unsigned STEPS_PER_TURN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] amount_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output spc_cmd_t    cmd_o
);

  // Reciprocal for an exact floor(amount / turn) over all 16-bit amounts
  localparam int unsigned ModW = $clog2(STEPS_PER_TURN);
  localparam int unsigned Shift = 16 + ModW;
  localparam longint unsigned RecipFull =
      ((64'd1 << Shift) + STEPS_PER_TURN - 1) / STEPS_PER_TURN;
  localparam logic [17:0] Recip = 18'(RecipFull);
  localparam logic [15:0] Turn = 16'(STEPS_PER_TURN);

  logic        a_valid_q;
  func_e       a_func_q;
  logic [15:0] a_amount_q;
  logic [33:0] a_prod_q;
  logic        a_ready;

  logic        b_valid_q;
  spc_cmd_t    b_cmd_q;
  logic        b_ready;

  logic [15:0] quot;
  logic [15:0] back;
  logic [15:0] rem;

  // Each stage takes a request when empty or when its successor takes one
  assign b_ready    = !b_valid_q || cmd_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Stage A: capture the request and multiply by the reciprocal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_func_q   <= func_e'(func_i);
      a_amount_q <= amount_i;
      a_prod_q   <= 34'(amount_i) * 34'(Recip);
    end
  end

  // Stage B: multiply the quotient back and subtract for the remainder
  assign quot = 16'(a_prod_q >> Shift);
  assign back = 16'(32'(quot) * 32'(Turn));
  assign rem  = a_amount_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_cmd_q.func       <= a_func_q;
      b_cmd_q.amount     <= a_amount_q;
      b_cmd_q.amount_mod <= rem;
    end
  end

  assign cmd_valid_o = b_valid_q;
  assign cmd_o       = b_cmd_q;

endmodule

>>> hdl/spc_core.sv
// Controller core: mode, position, target and relative flag, plus the result register.
// Uses spc_pkg and the assertion macros header.
`include "stepper_position_controller_macros.svh"

module spc_core
  import spc_pkg::*;
#(
  parameter int unsigned STEPS_PER_TURN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  spc_cmd_t    cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  step_dir_o,
  output logic [1:0]  mode_o,
  output logic [15:0] position_o
);

  localparam int unsigned ModW = $clog2(STEPS_PER_TURN);
  localparam logic [ModW-1:0] TurnMax = ModW'(STEPS_PER_TURN - 1);
  localparam logic [15:0] Turn = 16'(STEPS_PER_TURN);

  logic [1:0]      mode_q, mode_d;
  logic [15:0]     pos_q, pos_d;
  logic [ModW-1:0] pos_mod_q, pos_mod_d;  // position modulo one turn
  logic [15:0]     target_q, target_d;
  logic            rel_q, rel_d;
  logic [1:0]      dir_q, dir_d;
  logic            out_valid_q;

  logic            fire;
  logic            at_home;
  logic [15:0]     pos_h;
  logic            tgt_gt;
  logic [15:0]     dist_abs;
  logic [16:0]     dist2;
  logic            go_left;

  // Take a request when the result register is empty or being drained
  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  // Home detection and shortest-way decision
  assign at_home  = (pos_mod_q == '0);
  assign pos_h    = (!rel_q && at_home) ? 16'd0 : pos_q;
  assign tgt_gt   = (target_q > pos_h);
  assign dist_abs = tgt_gt ? (target_q - pos_h) : (pos_h - target_q);
  assign dist2    = {dist_abs, 1'b0};
  assign go_left  = tgt_gt ? (dist2 > 17'(Turn)) : (dist2 < 17'(Turn));

  // Next state for one request
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    pos_mod_d = pos_mod_q;
    target_d  = target_q;
    rel_d     = rel_q;
    dir_d     = DIR_NONE;
    unique case (cmd_i.func)
      FUNC_TICK: begin
        unique case (mode_q)
          MODE_CAL: begin
            if (at_home) begin
              pos_d     = 16'd0;
              pos_mod_d = '0;
              target_d  = 16'd0;
              mode_d    = MODE_IDLE;
            end else begin
              pos_d     = pos_q + 16'd1;
              pos_mod_d = (pos_q == 16'hFFFF || pos_mod_q == TurnMax) ? '0
                                                                      : pos_mod_q + ModW'(1);
              dir_d     = DIR_RIGHT;
            end
          end
          MODE_MOVE: begin
            if (pos_h == target_q) begin
              pos_d  = pos_h;
              mode_d = MODE_IDLE;
            end else if (!rel_q && go_left) begin
              // Position is within one turn here, so it equals its residue
              if (pos_h == 16'd0) begin
                pos_d     = Turn - 16'd1;
                pos_mod_d = TurnMax;
              end else begin
                pos_d     = pos_h - 16'd1;
                pos_mod_d = pos_mod_q - ModW'(1);
              end
              dir_d = DIR_LEFT;
            end else begin
              pos_d     = pos_h + 16'd1;
              pos_mod_d = (pos_h == 16'hFFFF || pos_mod_q == TurnMax) ? '0
                                                                      : pos_mod_q + ModW'(1);
              dir_d     = DIR_RIGHT;
            end
          end
          default: begin
            // Idle: hold everything
          end
        endcase
      end
      FUNC_GOTO: begin
        mode_d   = MODE_MOVE;
        pos_d    = 16'(pos_mod_q);
        target_d = cmd_i.amount_mod;
        rel_d    = 1'b0;
      end
      FUNC_REL: begin
        mode_d   = MODE_MOVE;
        target_d = pos_q + cmd_i.amount;
        rel_d    = 1'b1;
      end
      FUNC_CAL: begin
        mode_d = MODE_CAL;
        rel_d  = 1'b0;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  // Update state and result together; the state itself is the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CAL;
      pos_q       <= 16'd0;
      pos_mod_q   <= '0;
      target_q    <= 16'd0;
      rel_q       <= 1'b0;
      dir_q       <= DIR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_q    <= mode_d;
        pos_q     <= pos_d;
        pos_mod_q <= pos_mod_d;
        target_q  <= target_d;
        rel_q     <= rel_d;
        dir_q     <= dir_d;
      end
      if (cmd_ready_o) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign step_dir_o  = dir_q;
  assign mode_o      = mode_q;
  assign position_o  = pos_q;

  // Checks
  `SPC_ASSERT_IMPL(a_goto_within_turn, (mode_q == MODE_MOVE) && !rel_q, pos_q <= Turn, "go-to position left the turn")
  `SPC_ASSERT_IMPL(a_residue_tracks, pos_q < Turn, 16'(pos_mod_q) == pos_q, "position residue out of step")
  `SPC_ASSERT_NEXT(a_cmd_no_step, fire && (cmd_i.func != FUNC_TICK), dir_q == DIR_NONE, "command issued a step")
  `SPC_ASSERT_NEXT(a_hold_no_fire, !fire, $stable(pos_q) && $stable(mode_q) && $stable(dir_q), "state moved without a request")

endmodule

>>> hdl/stepper_position_controller.sv
// Pipeline: a request passes the two modulo stages, then the core register, before its result
// is offered.
// Throughput: one request per cycle, back to back, while the output is not stalled; a stalled
// output stalls all stages of the two-stage reciprocal modulo pipeline and the core.
// Reset (asynchronous, active low): mode calibrating, position, target and flag zero,
// pipeline empty.
module stepper_position_controller
  import spc_pkg::*;
#(
  parameter int unsigned STEPS_PER_TURN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  step_dir_o,
  output logic [1:0]  mode_o,
  output logic [15:0] position_o
);

  logic     cmd_valid;
  logic     cmd_ready;
  spc_cmd_t cmd;

  // Reduce go-to targets modulo one turn
  spc_mod_reduce #(
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) u_mod_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .amount_i   (amount_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // Apply each request to the controller state
  spc_core #(
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .step_dir_o (step_dir_o),
    .mode_o     (mode_o),
    .position_o (position_o)
  );

endmodule

>>> tb/sv/stepper_position_controller_tb.sv
// Self-checking testbench for stepper_position_controller: directed and random requests
// are checked against an in-bench model of mode, position, target and homing.
// Depends on spc_pkg and the RTL of the block only.
module stepper_position_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  localparam int unsigned TURN = 64;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    func_e       func;
    logic [15:0] amount;
  } stepper_req_t;

  typedef struct packed {
    logic [1:0]  step_dir;
    logic [1:0]  mode;
    logic [15:0] position;
  } motion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  func_drv = FUNC_TICK;
  logic [15:0] amount_drv = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  step_dir;
  logic [1:0]  mode;
  logic [15:0] position;

  stepper_req_t pending_reqs[$];
  motion_t      expected_motion[$];
  int unsigned  accepted_count = 0;
  int unsigned  mismatch_count = 0;
  logic         steady;

  // Model state of the controller
  logic [1:0]  mode_q = MODE_CAL;
  logic [15:0] pos_q = '0;
  logic [15:0] target_q = '0;
  logic        rel_q = 1'b0;

  stepper_position_controller #(
    .STEPS_PER_TURN(TURN)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .func_i     (func_drv),
    .amount_i   (amount_drv),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .step_dir_o (step_dir),
    .mode_o     (mode),
    .position_o (position)
  );

  always #6 clk = ~clk;

  // Run without idling on either side for a stretch of the random part
  assign steady = (accepted_count >= 600) && (accepted_count < 1100);

  // Apply one request to the model state and return the result it produces
  function automatic motion_t advance_motor(func_e f, logic [15:0] amt);
    motion_t     res;
    logic [1:0]  dir;
    int unsigned left_dist;
    int unsigned right_dist;
    dir = DIR_NONE;
    case (f)
      FUNC_TICK: begin
        if (mode_q == MODE_CAL) begin
          if (pos_q % TURN == 0) begin
            pos_q = '0;
            target_q = '0;
            mode_q = MODE_IDLE;
          end else begin
            pos_q = pos_q + 16'd1;
            dir = DIR_RIGHT;
          end
        end else if (mode_q == MODE_MOVE) begin
          // Home clears the position only under go-to
          if (!rel_q && (pos_q % TURN == 0)) pos_q = '0;
          if (pos_q == target_q) begin
            mode_q = MODE_IDLE;
          end else begin
            dir = DIR_RIGHT;
            if (!rel_q) begin
              if (target_q > pos_q) begin
                right_dist = target_q - pos_q;
                left_dist = TURN - right_dist;
              end else begin
                left_dist = pos_q - target_q;
                right_dist = TURN - left_dist;
              end
              // Ties go right
              if (left_dist < right_dist) dir = DIR_LEFT;
            end
            if (dir == DIR_LEFT) begin
              pos_q = (pos_q == 16'd0) ? 16'(TURN - 1) : pos_q - 16'd1;
            end else begin
              pos_q = pos_q + 16'd1;
            end
          end
        end
      end
      FUNC_GOTO: begin
        mode_q = MODE_MOVE;
        pos_q = 16'(pos_q % TURN);
        target_q = 16'(amt % TURN);
        rel_q = 1'b0;
      end
      FUNC_REL: begin
        mode_q = MODE_MOVE;
        target_q = pos_q + amt;
        rel_q = 1'b1;
      end
      default: begin
        rel_q = 1'b0;
        mode_q = MODE_CAL;
      end
    endcase
    res.step_dir = dir;
    res.mode = mode_q;
    res.position = pos_q;
    return res;
  endfunction

  task automatic push_req(func_e f, logic [15:0] amt);
    stepper_req_t r;
    r.func = f;
    r.amount = amt;
    pending_reqs.push_back(r);
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_req(FUNC_TICK, 16'($urandom));
  endtask

  // Driver: present queued requests, predict each one when it is accepted
  always @(posedge clk) begin
    stepper_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_motion.push_back(advance_motor(func_e'(func_drv), amount_drv));
        accepted_count <= accepted_count + 1;
      end
      if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        func_drv <= nxt.func;
        amount_drv <= nxt.amount;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation, stall at random
  always @(posedge clk) begin
    motion_t exp_m;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_motion.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: dir=%0d mode=%0d pos=%0d", step_dir, mode, position);
        end else begin
          exp_m = expected_motion.pop_front();
          if (step_dir !== exp_m.step_dir || mode !== exp_m.mode ||
              position !== exp_m.position) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected dir=%0d mode=%0d pos=%0d, got dir=%0d mode=%0d pos=%0d",
                       exp_m.step_dir, exp_m.mode, exp_m.position, step_dir, mode, position);
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned random_count;
    int unsigned pick;
    int unsigned n;

    // Directed: home at reset, left step from zero, wrap past home, tie, relative, calibrate
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_TICK, 16'hFFFF);
    push_req(FUNC_GOTO, 16'hFFFF);
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_GOTO, 16'h0000);
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_GOTO, 16'd32);
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_REL, 16'h0000);
    push_req(FUNC_TICK, 16'h0000);
    push_req(FUNC_REL, 16'd3);
    push_ticks(4);
    push_req(FUNC_CAL, 16'hFFFF);
    push_ticks(2);
    push_req(FUNC_GOTO, 16'd6);
    push_req(FUNC_TICK, 16'h0000);

    // Random: mostly a command followed by a run of ticks, some noise
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_req(FUNC_GOTO, 16'($urandom));
        n = $urandom_range(40);
      end else if (pick < 52) begin
        push_req(FUNC_REL, 16'($urandom_range(80)));
        n = $urandom_range(90);
      end else if (pick < 56) begin
        push_req(FUNC_REL, 16'($urandom));
        n = $urandom_range(40);
      end else if (pick < 70) begin
        push_req(FUNC_CAL, 16'($urandom));
        n = $urandom_range(70);
      end else if (pick < 85) begin
        n = $urandom_range(10, 1);
      end else begin
        push_req(func_e'($urandom_range(3)), 16'($urandom));
        n = 0;
      end
      push_ticks(n);
      random_count += n + ((pick < 70 || pick >= 85) ? 1 : 0);
    end

    // Home, then a short relative run from there
    push_req(FUNC_CAL, 16'h0000);
    push_ticks(70);
    push_req(FUNC_REL, 16'd3);
    push_ticks(4);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then let the pipeline settle
    while (pending_reqs.size() != 0 || in_valid || expected_motion.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
